>>> design/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the lru key/value cache: opcodes, sequencer
// states, controller-to-datapath command and status words.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int unsigned CAP_W  = 5;
  localparam int unsigned WORD_W = 32;

  // data returned on a get that misses
  localparam logic signed [WORD_W-1:0] MISS_DATA = -32'sd1;

  // register index, taken from paddr bit 2
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RESPOND
  } state_e;

  typedef struct packed {
    logic load;     // capture the request word
    logic lookup;   // compare keys, find victim
    logic update;   // write slot, age ranks, read value
    logic respond;  // drive the result word
  } cmd_t;

  typedef struct packed {
    logic is_put;
  } status_t;

endpackage

>>> design/lrukv_ctrl.sv
// ----------------------------------------------------------------------------
// lrukv_ctrl
// Request sequencer: idle, lookup, update and, for a get, respond.
// ----------------------------------------------------------------------------
module lrukv_ctrl
  import lrukv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        // puts give no result word
        state_d = status_i.is_put ? ST_IDLE : ST_RESPOND;
      end
      ST_RESPOND: begin
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/lrukv_dpath.sv
// ----------------------------------------------------------------------------
// lrukv_dpath
// Entry row (keys, recency ranks), value memory, fill count, key compare,
// victim search and recency aging.
// ----------------------------------------------------------------------------
module lrukv_dpath
  import lrukv_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic [CAP_W-1:0]         capacity_i,
  input  logic                     opcode_i,
  input  logic [WORD_W-1:0]        key_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     empty_o,
  output logic                     found_o,
  output logic signed [WORD_W-1:0] data_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // request word
  logic                     op_q;
  logic [WORD_W-1:0]        key_q;
  logic signed [WORD_W-1:0] val_q;

  // entry row
  logic [WORD_W-1:0] keys_q  [ENTRIES];
  logic [IDX_W-1:0]  rank_q  [ENTRIES];
  logic [CNT_W-1:0]  count_q;

  // value memory
  logic signed [WORD_W-1:0] vals_mem [ENTRIES];
  logic signed [WORD_W-1:0] rd_q;

  logic [ENTRIES-1:0] hit_q, victim_q;
  logic               found_q;

  logic [CMP_W-1:0] cap_w;
  logic [CNT_W-1:0] eff_cap;
  logic             full;
  logic             any_hit;
  logic [IDX_W-1:0] hit_idx, victim_idx, slot;
  logic [IDX_W-1:0] rank_sel, touch_rank;
  logic [CNT_W-1:0] count_m1;
  logic             touch_en, insert;

  assign status_o.is_put = (op_q == OP_PUT);
  assign empty_o         = (count_q == '0);
  assign count_m1        = count_q - CNT_W'(1);

  // capacity zero acts as one, above the row it saturates
  always_comb begin
    cap_w = CMP_W'(capacity_i);
    if (cap_w == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_w > CMP_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_w);
    end
  end

  assign full = (count_q >= eff_cap);

  // one-hot to index, and rank of the hit slot
  always_comb begin
    any_hit    = |hit_q;
    hit_idx    = '0;
    victim_idx = '0;
    rank_sel   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_q[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        rank_sel = rank_sel | rank_q[i];
      end
      if (victim_q[i]) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    insert     = 1'b0;
    touch_rank = rank_sel;
    if (any_hit) begin
      slot = hit_idx;
    end else if (full) begin
      slot       = victim_idx;
      touch_rank = IDX_W'(count_m1);
    end else begin
      slot       = IDX_W'(count_q);
      touch_rank = IDX_W'(count_q);
      insert     = status_o.is_put;
    end
    touch_en = status_o.is_put || any_hit;
  end

  // request capture, compare and victim search, hit flag and key write
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (cmd_i.lookup) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_q[i]    <= (CNT_W'(i) < count_q) && (keys_q[i] == key_q);
        victim_q[i] <= (CNT_W'(i) < count_q) && (rank_q[i] == IDX_W'(count_m1));
      end
    end
    if (cmd_i.update) begin
      found_q <= any_hit;
      if (status_o.is_put && !any_hit) begin
        keys_q[slot] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (status_o.is_put) begin
        vals_mem[slot] <= val_q;
      end
      rd_q <= vals_mem[slot];
    end
  end

  // recency aging and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update && touch_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank_q[i] <= '0;
        end else if ((CNT_W'(i) < count_q) && (rank_q[i] < touch_rank)) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end
      if (insert) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign found_o = found_q;
  assign data_o  = found_q ? rd_q : MISS_DATA;

endmodule

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Request channel: drive opcode_i, key_i, value_i with start high; the word is
// taken at the edge where start is high and busy is low. opcode get looks the
// key up, put inserts or updates it.
// Result channel: a get produces one word on found_o/data_o, marked by
// result_valid_o for exactly one cycle, in the respond state after update.
// A miss gives found 0 and data -1. A put produces no word.
// Sequencing: a get runs lookup with a parallel key compare, update of the slot
// and the recency ranks, then respond with the registered value read; a put
// ends after update. The next word is taken once busy drops.
// Configuration: apb port, capacity at byte address 0, written only while the
// cache is empty, read back as written. pready is always high.
// Reset: the cache is empty, capacity 16, no result pending. The receiver
// cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lrukv_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic [WORD_W-1:0]        key_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     result_valid_o,
  output logic                     found_o,
  output logic signed [WORD_W-1:0] data_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cmd_t             cmd;
  status_t          status;
  logic             empty;
  logic [CAP_W-1:0] capacity_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // capacity only changes while the store is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY) && empty) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : '0;

  lrukv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  lrukv_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .capacity_i (capacity_q),
    .opcode_i   (opcode_i),
    .key_i      (key_i),
    .value_i    (value_i),
    .empty_o    (empty),
    .found_o    (found_o),
    .data_o     (data_o)
  );

  assign result_valid_o = cmd.respond;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted request did not occupy the sequencer");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside of a request");

  a_miss_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (data_o == MISS_DATA))
    else $error("miss did not return not-found data");

endmodule
